### design/a64x_pkg.sv
// Shared constants for the A64 integer subset execute unit.
// Used by design/a64_subset_execute_unit.sv; depends on nothing.
package a64x_pkg;

  localparam int unsigned MEM_BYTES_DEF = 2097152;
  localparam int unsigned NUM_REGS_DEF  = 31;

  localparam int unsigned IN_W  = 96;
  localparam int unsigned OUT_W = 136;

  // Instruction kinds.
  localparam logic [3:0] K_ADDI  = 4'd0;
  localparam logic [3:0] K_MOVW  = 4'd1;
  localparam logic [3:0] K_ADDR  = 4'd2;
  localparam logic [3:0] K_LOGIC = 4'd3;
  localparam logic [3:0] K_MUL   = 4'd4;
  localparam logic [3:0] K_LDROFF = 4'd5;
  localparam logic [3:0] K_PRE   = 4'd6;
  localparam logic [3:0] K_POST  = 4'd7;
  localparam logic [3:0] K_UOFF  = 4'd8;
  localparam logic [3:0] K_LIT   = 4'd9;
  localparam logic [3:0] K_B     = 4'd10;
  localparam logic [3:0] K_BR    = 4'd11;
  localparam logic [3:0] K_BCOND = 4'd12;
  localparam logic [3:0] K_IMG   = 4'd13;

  // Suboperations.
  localparam logic [2:0] OP_MOVN  = 3'd0;
  localparam logic [2:0] OP_MOVZ  = 3'd1;
  localparam logic [2:0] OP_MOVK  = 3'd2;
  localparam logic [2:0] OP_STORE = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_MSUB  = 3'd1;

  localparam logic [2:0] COND_EQ = 3'd0;
  localparam logic [2:0] COND_NE = 3'd1;
  localparam logic [2:0] COND_GE = 3'd2;
  localparam logic [2:0] COND_LT = 3'd3;
  localparam logic [2:0] COND_GT = 3'd4;
  localparam logic [2:0] COND_LE = 3'd5;
  localparam logic [2:0] COND_AL = 3'd6;
  localparam logic [2:0] COND_NV = 3'd7;

  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  localparam logic [1:0] LG_AND  = 2'd0;
  localparam logic [1:0] LG_ORR  = 2'd1;
  localparam logic [1:0] LG_EOR  = 2'd2;
  localparam logic [1:0] LG_ANDS = 2'd3;

  localparam logic [4:0] ZERO_REG = 5'd31;

endpackage

### design/a64_subset_execute_unit.sv
// Execute unit for a subset of A64 integer instructions, with register file
// and byte memory held in synchronous RAMs. Depends on design/a64x_pkg.sv.
//
//  channel | dir | payload (tdata, lowest bits first)
//  s_axis  | in  | kind, op, wide, rd, rn, rm, ra, shift_type, shift_amount,
//          |     | imm, imm_shift, image_word
//  m_axis  | out | next_pc, flags, written_value, fault
//
// An instruction has a step that reads the register RAMs and one that
// computes and reads the memory banks; results commit as the next one starts,
// so a new transfer is taken once the last has left the compute step, and
// only while the output drains. After reset all MEM_BYTES/16+1 words of each
// memory bank are cleared, with s_axis_tready low. A stalled output holds the
// finished instruction in the last stage, which in turn blocks the input.
module a64_subset_execute_unit #(
  parameter int unsigned MEM_BYTES = a64x_pkg::MEM_BYTES_DEF,
  parameter int unsigned NUM_REGS  = a64x_pkg::NUM_REGS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // kind[3:0] op[6:4] wide[7] rd[12:8] rn[17:13] rm[22:18] ra[27:23]
  // shift_type[29:28] shift_amount[35:30] imm[61:36] imm_shift[63:62]
  // image_word[95:64]
  input  logic [a64x_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // next_pc[63:0] flags[67:64] written_value[131:68] fault[132], zero above
  output logic [a64x_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int unsigned AW    = $clog2(MEM_BYTES);
  localparam int unsigned DEPTH = MEM_BYTES / 16 + 1;
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(NUM_REGS);

  // ---------------------------------------------------------------- control
  logic          clearing;
  logic [IW-1:0] clr_idx;
  logic          e_v, m_v, out_v;
  logic          accept, m_done;

  assign m_done        = m_v && (!out_v || m_axis_tready);
  assign s_axis_tready = !clearing && !e_v && (!m_v || m_done);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------- register RAMs
  logic [63:0] rf_a [NUM_REGS];
  logic [63:0] rf_b [NUM_REGS];
  logic [63:0] rf_c [NUM_REGS];
  logic [NUM_REGS-1:0] rvalid;

  logic [4:0]  in_rd, in_rn, in_rm, in_ra, in_rc;
  logic [3:0]  in_kind;
  logic [63:0] rd_a, rd_b, rd_c;
  logic        rv_a, rv_b, rv_c;

  assign in_kind = s_axis_tdata[3:0];
  assign in_rd   = s_axis_tdata[12:8];
  assign in_rn   = s_axis_tdata[17:13];
  assign in_rm   = s_axis_tdata[22:18];
  assign in_ra   = s_axis_tdata[27:23];
  assign in_rc   = (in_kind == a64x_pkg::K_MUL) ? in_ra : in_rd;

  // Register write port: the destination at commit, the base writeback
  // afterwards from a pending register, held while a commit takes the port.
  logic          rf_we;
  logic [4:0]    rf_wa;
  logic [63:0]   rf_wd;
  logic          wb_pend;
  logic [4:0]    wb_pend_a;
  logic [63:0]   wb_pend_d;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_a[rf_wa[RW-1:0]] <= rf_wd;
      rf_b[rf_wa[RW-1:0]] <= rf_wd;
      rf_c[rf_wa[RW-1:0]] <= rf_wd;
    end
    if (accept) begin
      rd_a <= rf_a[in_rn[RW-1:0]];
      rd_b <= rf_b[in_rm[RW-1:0]];
      rd_c <= rf_c[in_rc[RW-1:0]];
      rv_a <= (32'(in_rn) < NUM_REGS) && rvalid[in_rn[RW-1:0]];
      rv_b <= (32'(in_rm) < NUM_REGS) && rvalid[in_rm[RW-1:0]];
      rv_c <= (32'(in_rc) < NUM_REGS) && rvalid[in_rc[RW-1:0]];
    end
  end

  // -------------------------------------------------------------- E stage
  logic [3:0]  e_kind;
  logic [2:0]  e_op;
  logic        e_wide;
  logic [4:0]  e_rd, e_rn, e_rm, e_rc;
  logic [1:0]  e_st;
  logic [5:0]  e_sa;
  logic [25:0] e_imm;
  logic [1:0]  e_ish;
  logic [31:0] e_word;

  always_ff @(posedge clk) begin
    if (accept) begin
      e_kind <= in_kind;
      e_op   <= s_axis_tdata[6:4];
      e_wide <= s_axis_tdata[7];
      e_rd   <= in_rd;
      e_rn   <= in_rn;
      e_rm   <= in_rm;
      e_rc   <= in_rc;
      e_st   <= s_axis_tdata[29:28];
      e_sa   <= s_axis_tdata[35:30];
      e_imm  <= s_axis_tdata[61:36];
      e_ish  <= s_axis_tdata[63:62];
      e_word <= s_axis_tdata[95:64];
    end
  end

  // Last register writes, forwarded to an instruction whose RAM read raced them.
  logic        fw_rd_en, fw_wb_en;
  logic [4:0]  fw_rd_a, fw_wb_a;
  logic [63:0] fw_rd_d, fw_wb_d;

  logic [63:0] va, vb, vc;
  always_comb begin
    va = rv_a ? rd_a : 64'd0;
    if (fw_wb_en && fw_wb_a == e_rn) va = fw_wb_d;
    if (fw_rd_en && fw_rd_a == e_rn) va = fw_rd_d;
    if (e_rn == a64x_pkg::ZERO_REG) va = 64'd0;
    vb = rv_b ? rd_b : 64'd0;
    if (fw_wb_en && fw_wb_a == e_rm) vb = fw_wb_d;
    if (fw_rd_en && fw_rd_a == e_rm) vb = fw_rd_d;
    if (e_rm == a64x_pkg::ZERO_REG) vb = 64'd0;
    vc = rv_c ? rd_c : 64'd0;
    if (fw_wb_en && fw_wb_a == e_rc) vc = fw_wb_d;
    if (fw_rd_en && fw_rd_a == e_rc) vc = fw_rd_d;
    if (e_rc == a64x_pkg::ZERO_REG) vc = 64'd0;
  end

  logic [63:0] pc;
  logic [3:0]  cond_flags;

  logic [63:0]  mask, ma, mb, shx, shv, ar_b, ar_r, lg_b, lg_r, hw, sext9;
  logic [127:0] rot_w;
  logic [63:0]  rot_n;
  logic [64:0]  sum65;
  logic [63:0]  diff;
  logic         ar_c, ar_v, ar_n, ar_z, lg_n, lg_z;
  logic [63:0]  addr, nb, limit, lit_off;
  logic         ldst_ok, cond_ok, is_load, sz8;
  logic         fl_n, fl_z, fl_v;

  assign mask  = e_wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
  assign ma    = va & mask;
  assign shx   = vb & mask;
  assign sext9 = {{55{e_imm[8]}}, e_imm[8:0]};
  assign lit_off = {{43{e_imm[18]}}, e_imm[18:0], 2'b00};

  // Second-operand shifter; a rotate is a shift of the doubled word.
  always_comb begin
    rot_w = e_wide ? ({shx, shx} >> e_sa)
                   : {64'd0, 64'({shx[31:0], shx[31:0]} >> e_sa[4:0])};
    rot_n = rot_w[63:0] & mask;
    case (e_st)
      a64x_pkg::SH_LSL: shv = (shx << e_sa) & mask;
      a64x_pkg::SH_LSR: shv = shx >> e_sa;
      a64x_pkg::SH_ASR: shv = e_wide ? 64'($signed(shx) >>> e_sa)
                                     : {32'd0, 32'($signed(shx[31:0]) >>> e_sa[4:0])};
      default:          shv = rot_n;
    endcase
  end

  always_comb begin
    ar_b  = (e_kind == a64x_pkg::K_ADDI)
            ? ({52'd0, e_imm[11:0]} << (e_ish[0] ? 12 : 0)) : shv;
    ar_b  = ar_b & mask;
    sum65 = {1'b0, ma} + {1'b0, ar_b};
    diff  = ma - ar_b;
    if (e_op[1]) begin
      ar_r = diff & mask;
      ar_c = ma >= ar_b;
      fl_v = e_wide ? (((ma ^ ar_b) & (ma ^ ar_r)) >> 63) != 64'd0
                    : ((((ma ^ ar_b) & (ma ^ ar_r)) >> 31) & 64'd1) != 64'd0;
    end else begin
      ar_r = sum65[63:0] & mask;
      ar_c = e_wide ? sum65[64] : sum65[32];
      fl_v = e_wide ? (((~(ma ^ ar_b)) & (ma ^ ar_r)) >> 63) != 64'd0
                    : ((((~(ma ^ ar_b)) & (ma ^ ar_r)) >> 31) & 64'd1) != 64'd0;
    end
    ar_v = fl_v;
    ar_n = e_wide ? ar_r[63] : ar_r[31];
    ar_z = ar_r == 64'd0;

    lg_b = e_op[0] ? (~shv & mask) : shv;
    case (e_op[2:1])
      a64x_pkg::LG_ORR: lg_r = ma | lg_b;
      a64x_pkg::LG_EOR: lg_r = ma ^ lg_b;
      default:          lg_r = ma & lg_b;
    endcase
    lg_n = e_wide ? lg_r[63] : lg_r[31];
    lg_z = lg_r == 64'd0;

    hw = {48'd0, e_imm[15:0]} << {e_ish, 4'b0000};
  end

  always_comb begin
    fl_n = cond_flags[3];
    fl_z = cond_flags[2];
    case (e_op)
      a64x_pkg::COND_EQ: cond_ok = fl_z;
      a64x_pkg::COND_NE: cond_ok = !fl_z;
      a64x_pkg::COND_GE: cond_ok = fl_n == cond_flags[0];
      a64x_pkg::COND_LT: cond_ok = fl_n != cond_flags[0];
      a64x_pkg::COND_GT: cond_ok = !fl_z && fl_n == cond_flags[0];
      a64x_pkg::COND_LE: cond_ok = fl_z || fl_n != cond_flags[0];
      default:           cond_ok = 1'b1;
    endcase
  end

  // Address generation and range check.
  always_comb begin
    sz8 = e_wide && e_kind != a64x_pkg::K_IMG;
    nb  = va + sext9;
    case (e_kind)
      a64x_pkg::K_LDROFF: addr = va + vb;
      a64x_pkg::K_PRE:    addr = nb;
      a64x_pkg::K_POST:   addr = va;
      a64x_pkg::K_UOFF:   addr = va + ({52'd0, e_imm[11:0]} << (e_wide ? 3 : 2));
      a64x_pkg::K_LIT:    addr = pc + lit_off;
      default:            addr = {36'd0, e_imm, 2'b00};
    endcase
    limit   = 64'(MEM_BYTES) - (sz8 ? 64'd8 : 64'd4);
    ldst_ok = addr <= limit;
    is_load = e_kind == a64x_pkg::K_LIT || e_op == a64x_pkg::OP_LOAD;
  end

  // Per-kind outcome.
  logic        x_fault, x_flags_we, x_rd_we, x_wb_we, x_mem_we, x_mul, x_load;
  logic [3:0]  x_flags;
  logic [63:0] x_val, x_next;

  always_comb begin
    x_fault    = 1'b0;
    x_flags_we = 1'b0;
    x_flags    = 4'd0;
    x_rd_we    = 1'b0;
    x_wb_we    = 1'b0;
    x_mem_we   = 1'b0;
    x_mul      = 1'b0;
    x_load     = 1'b0;
    x_val      = 64'd0;
    x_next     = pc + 64'd4;
    case (e_kind)
      a64x_pkg::K_ADDI, a64x_pkg::K_ADDR: begin
        if (e_op > 3'd3 ||
            (e_kind == a64x_pkg::K_ADDI && e_ish > 2'd1) ||
            (e_kind == a64x_pkg::K_ADDR &&
             (e_st == a64x_pkg::SH_ROR || (!e_wide && e_sa[5])))) begin
          x_fault = 1'b1;
        end else begin
          x_val      = ar_r;
          x_rd_we    = 1'b1;
          x_flags_we = e_op[0];
          x_flags    = {ar_n, ar_z, ar_c, ar_v};
        end
      end
      a64x_pkg::K_MOVW: begin
        if (e_op > a64x_pkg::OP_MOVK || (!e_wide && e_ish > 2'd1)) begin
          x_fault = 1'b1;
        end else begin
          x_rd_we = 1'b1;
          case (e_op)
            a64x_pkg::OP_MOVN: x_val = ~hw & mask;
            a64x_pkg::OP_MOVZ: x_val = hw;
            default: x_val = ((vc & ~(64'hFFFF << {e_ish, 4'b0000})) | hw) & mask;
          endcase
        end
      end
      a64x_pkg::K_LOGIC: begin
        if (!e_wide && e_sa[5]) begin
          x_fault = 1'b1;
        end else begin
          x_val      = lg_r;
          x_rd_we    = 1'b1;
          x_flags_we = e_op[2:1] == a64x_pkg::LG_ANDS;
          x_flags    = {lg_n, lg_z, 2'b00};
        end
      end
      a64x_pkg::K_MUL: begin
        if (e_op > a64x_pkg::OP_MSUB) begin
          x_fault = 1'b1;
        end else begin
          x_rd_we = 1'b1;
          x_mul   = 1'b1;
        end
      end
      a64x_pkg::K_LDROFF, a64x_pkg::K_PRE, a64x_pkg::K_POST, a64x_pkg::K_UOFF,
      a64x_pkg::K_LIT: begin
        if ((e_kind != a64x_pkg::K_LIT && e_op > a64x_pkg::OP_LOAD) || !ldst_ok) begin
          x_fault = 1'b1;
        end else begin
          // A load into its own base register keeps the loaded value.
          x_wb_we = (e_kind == a64x_pkg::K_PRE || e_kind == a64x_pkg::K_POST) &&
                    !(is_load && e_rd == e_rn);
          if (is_load) begin
            x_load  = 1'b1;
            x_rd_we = 1'b1;
          end else begin
            x_mem_we = 1'b1;
            x_val    = vc & mask;
          end
        end
      end
      a64x_pkg::K_B:  x_next = pc + {{36{e_imm[25]}}, e_imm, 2'b00};
      a64x_pkg::K_BR: x_next = va;
      a64x_pkg::K_BCOND: begin
        if (e_op == a64x_pkg::COND_NV) x_fault = 1'b1;
        else if (cond_ok) x_next = pc + lit_off;
      end
      a64x_pkg::K_IMG: begin
        x_next = pc;
        if (!ldst_ok) begin
          x_fault = 1'b1;
        end else begin
          x_mem_we = 1'b1;
          x_val    = {32'd0, e_word};
        end
      end
      default: x_fault = 1'b1;
    endcase
  end

  // Bank addressing: byte address splits into a word index and an offset,
  // an access spans that word and the next, which sit in opposite banks.
  logic [AW-4:0]  e_w;
  logic [IW-1:0]  e_even_idx, e_odd_idx;
  logic [127:0]   e_wd128;
  logic [15:0]    e_be16;

  assign e_w        = addr[AW-1:3];
  assign e_even_idx = IW'(({1'b0, e_w} + (AW-2)'(1)) >> 1);
  assign e_odd_idx  = IW'(e_w >> 1);
  assign e_wd128    = {64'd0, x_val} << {addr[2:0], 3'b000};
  assign e_be16     = {8'd0, (sz8 ? 8'hFF : 8'h0F)} << addr[2:0];

  // -------------------------------------------------------------- M stage
  logic          m_fault, m_flags_we, m_rd_we, m_wb_we, m_mem_we, m_mul, m_load;
  logic          m_msub, m_wodd;
  logic [3:0]    m_flags;
  logic [63:0]   m_val, m_next, m_nb, m_mask, m_ra;
  logic [4:0]    m_rd, m_rn;
  logic [2:0]    m_off;
  logic [IW-1:0] m_even_idx, m_odd_idx;
  logic [127:0]  m_wd128;
  logic [15:0]   m_be16;
  logic [63:0]   m_pl;
  logic [31:0]   m_c1, m_c2;
  logic [63:0]   mb_lo;

  assign mb = vb & mask;

  always_ff @(posedge clk) begin
    if (e_v) begin
      m_fault    <= x_fault;
      m_flags_we <= x_flags_we && !x_fault;
      m_flags    <= x_flags;
      m_rd_we    <= x_rd_we && !x_fault;
      m_wb_we    <= x_wb_we && !x_fault;
      m_mem_we   <= x_mem_we && !x_fault;
      m_mul      <= x_mul;
      m_load     <= x_load;
      m_msub     <= e_op[0];
      m_val      <= x_fault ? 64'd0 : x_val;
      m_next     <= x_fault ? ((e_kind == a64x_pkg::K_IMG) ? pc : pc + 64'd4) : x_next;
      m_nb       <= nb;
      m_mask     <= mask;
      m_ra       <= vc;
      m_rd       <= e_rd;
      m_rn       <= e_rn;
      m_off      <= addr[2:0];
      m_wodd     <= e_w[0];
      m_even_idx <= e_even_idx;
      m_odd_idx  <= e_odd_idx;
      m_wd128    <= e_wd128;
      m_be16     <= e_be16;
      // Low 64 bits of the product from three 32x32 partial products.
      m_pl       <= 64'(ma[31:0]) * 64'(mb[31:0]);
      m_c1       <= 32'(ma[31:0] * mb[63:32]);
      m_c2       <= 32'(ma[63:32] * mb[31:0]);
    end
  end

  // ------------------------------------------------------------ memory banks
  logic [63:0] mem_even [DEPTH];
  logic [63:0] mem_odd  [DEPTH];
  logic [63:0] q_even, q_odd;

  logic          be_we_even, be_we_odd;
  logic [IW-1:0] w_idx_even, w_idx_odd;
  logic [63:0]   w_d_even, w_d_odd;
  logic [7:0]    w_be_even, w_be_odd;

  always_comb begin
    if (clearing) begin
      be_we_even = 1'b1;
      be_we_odd  = 1'b1;
      w_idx_even = clr_idx;
      w_idx_odd  = clr_idx;
      w_d_even   = 64'd0;
      w_d_odd    = 64'd0;
      w_be_even  = 8'hFF;
      w_be_odd   = 8'hFF;
    end else begin
      be_we_even = m_done && m_mem_we;
      be_we_odd  = m_done && m_mem_we;
      w_idx_even = m_even_idx;
      w_idx_odd  = m_odd_idx;
      w_d_even   = m_wodd ? m_wd128[127:64] : m_wd128[63:0];
      w_d_odd    = m_wodd ? m_wd128[63:0]   : m_wd128[127:64];
      w_be_even  = m_wodd ? m_be16[15:8]    : m_be16[7:0];
      w_be_odd   = m_wodd ? m_be16[7:0]     : m_be16[15:8];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      if (be_we_even && w_be_even[i]) mem_even[w_idx_even][8*i +: 8] <= w_d_even[8*i +: 8];
      if (be_we_odd && w_be_odd[i])   mem_odd[w_idx_odd][8*i +: 8]   <= w_d_odd[8*i +: 8];
    end
    if (e_v) begin
      q_even <= mem_even[e_even_idx];
      q_odd  <= mem_odd[e_odd_idx];
    end
  end

  // Commit values.
  logic [127:0] ld_pair, ld_sh;
  logic [63:0]  mul_p, f_val;
  logic [3:0]   f_flags;

  always_comb begin
    ld_pair = m_wodd ? {q_even, q_odd} : {q_odd, q_even};
    ld_sh   = ld_pair >> {m_off, 3'b000};
    mul_p   = m_pl + {m_c1 + m_c2, 32'd0};
    mb_lo   = m_msub ? (m_ra - mul_p) : (m_ra + mul_p);
    if (m_fault)     f_val = 64'd0;
    else if (m_mul)  f_val = mb_lo & m_mask;
    else if (m_load) f_val = ld_sh[63:0] & m_mask;
    else             f_val = m_val;
    f_flags = m_flags_we ? m_flags : cond_flags;
  end

  always_comb begin
    if (m_done && m_rd_we && m_rd != a64x_pkg::ZERO_REG) begin
      rf_we = 1'b1;
      rf_wa = m_rd;
      rf_wd = f_val;
    end else begin
      rf_we = wb_pend;
      rf_wa = wb_pend_a;
      rf_wd = wb_pend_d;
    end
  end

  localparam int unsigned OUT_W_LOCAL = a64x_pkg::OUT_W;
  logic [OUT_W_LOCAL-1:0] out_data;

  always_ff @(posedge clk) begin
    if (m_done) out_data <= {3'd0, m_fault, f_val, f_flags, m_next};
  end
  assign m_axis_tdata  = out_data;
  assign m_axis_tvalid = out_v;

  // ------------------------------------------------------- sequential control
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clr_idx    <= '0;
      e_v        <= 1'b0;
      m_v        <= 1'b0;
      out_v      <= 1'b0;
      pc         <= 64'd0;
      cond_flags <= 4'd0;
      rvalid     <= '0;
      wb_pend    <= 1'b0;
      fw_rd_en   <= 1'b0;
      fw_wb_en   <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + IW'(1);
        if (clr_idx == IW'(DEPTH - 1)) clearing <= 1'b0;
      end
      e_v   <= accept;
      m_v   <= e_v || (m_v && !m_done);
      out_v <= m_done || (out_v && !m_axis_tready);
      if (rf_we) rvalid[rf_wa[RW-1:0]] <= 1'b1;
      if (wb_pend && !(m_done && m_rd_we && m_rd != a64x_pkg::ZERO_REG)) wb_pend <= 1'b0;
      if (m_done) begin
        pc         <= m_next;
        cond_flags <= f_flags;
        fw_rd_en   <= m_rd_we && m_rd != a64x_pkg::ZERO_REG;
        fw_rd_a    <= m_rd;
        fw_rd_d    <= f_val;
        fw_wb_en   <= m_wb_we && m_rn != a64x_pkg::ZERO_REG;
        fw_wb_a    <= m_rn;
        fw_wb_d    <= m_nb;
        wb_pend    <= m_wb_we && m_rn != a64x_pkg::ZERO_REG;
        wb_pend_a  <= m_rn;
        wb_pend_d  <= m_nb;
      end
    end
  end

endmodule
